>>> design/lcdsm_pkg.sv
// ----------------------------------------------------------------------------
// lcdsm_pkg
// Shared types and timing constants for the LCD scanline and mode timer.
// ----------------------------------------------------------------------------
package lcdsm_pkg;

  // Line timing in dot cycles
  localparam logic [9:0] DOTS_PER_LINE = 10'd456;
  localparam logic [9:0] OAM_END       = 10'd80;
  localparam logic [9:0] DRAW_END      = 10'd252;

  // Line numbers
  localparam logic [7:0] LAST_LINE         = 8'd153;
  localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
  localparam logic [7:0] VBLANK_LINE       = 8'h90;

  // Mode codes as shown in the status register
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Status interrupt enable bits
  localparam int unsigned EN_HBLANK  = 0;
  localparam int unsigned EN_VBLANK  = 1;
  localparam int unsigned EN_OAM     = 2;
  localparam int unsigned EN_COMPARE = 3;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // One input transaction, highest field first
  typedef struct packed {
    logic [3:0] stat_enables;
    logic [7:0] compare_line;
    logic       lcd_enable;
    logic [5:0] cycles;
  } in_item_t;

  // One result transaction, highest field first
  typedef struct packed {
    logic       frame_done;
    logic       draw_line;
    logic       vblank_irq;
    logic       stat_irq;
    logic       coincidence;
    logic [1:0] mode;
    logic [7:0] line;
  } out_item_t;

endpackage

>>> design/lcd_scanline_mode_timer.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer
// Scanline counter and display mode sequencer for an LCD controller.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one transaction per batch
//   of elapsed dot cycles together with the enable bit, the line compare
//   value and the status interrupt enables. Master stream (m_tvalid/m_tready/
//   m_tdata) returns exactly one result per input: line, mode, compare flag,
//   interrupt requests and the draw and frame strobes.
//   An accepted input goes to an input register, then through one pass of
//   add/compare logic into the result register, which also updates the
//   dot, line, mode and compare state. Throughput is one transaction per
//   cycle while m_tready is high; the state update path (one 10-bit add,
//   subtract and compares) is combinational.
//   Reset (rst, synchronous) empties both registers and clears the dot
//   counter, line, mode (hblank) and compare flag.
//   When the receiver stalls, the result holds in the output register and
//   one more input is taken into the input register; s_tready then drops
//   until the result is taken.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [5:0] cycles, [6] lcd_enable, [14:7] compare_line, [18:15] stat_enables
  input  logic [lcdsm_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] line, [9:8] mode, [10] coincidence, [11] stat_irq,
  // [12] vblank_irq, [13] draw_line, [14] frame_done
  output logic [lcdsm_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import lcdsm_pkg::*;

  logic       in_valid;
  in_item_t   in_item;
  logic       advance;

  logic [9:0] dot_count;
  logic [7:0] line_reg;
  logic [1:0] mode_reg;
  logic       coincidence_reg;

  logic [9:0] dot_sum;
  logic [7:0] line_inc;
  logic [9:0] dot_next;
  logic [7:0] line_next;
  logic [1:0] mode_next;
  logic       coincidence_next;
  out_item_t  res_next;
  out_item_t  res;

  // Move the held item forward whenever the result register is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    end
  end

  // Step the dot counter, line and mode for one transaction
  always_comb begin
    dot_sum          = dot_count + {4'd0, in_item.cycles};
    line_inc         = line_reg + 8'd1;
    dot_next         = dot_count;
    line_next        = line_reg;
    mode_next        = mode_reg;
    coincidence_next = coincidence_reg;
    res_next         = '0;
    if (in_item.lcd_enable) begin
      dot_next = dot_sum;
      // Advance the line past the end of a line
      if (dot_sum > DOTS_PER_LINE) begin
        line_next        = line_inc;
        coincidence_next = (line_inc == in_item.compare_line);
        if (coincidence_next && in_item.stat_enables[EN_COMPARE]) begin
          res_next.stat_irq = 1'b1;
        end
        // Wrap to the top of the frame
        if (line_inc > LAST_LINE) begin
          res_next.frame_done = 1'b1;
          mode_next           = MODE_OAM;
          line_next           = 8'd0;
          if (in_item.stat_enables[EN_OAM]) begin
            res_next.stat_irq = 1'b1;
          end
        end
        dot_next = dot_sum - DOTS_PER_LINE;
      end
      // Select the mode from line and dot position
      if (line_next > LAST_VISIBLE_LINE) begin
        if (mode_next != MODE_VBLANK) begin
          mode_next = MODE_VBLANK;
          if (in_item.stat_enables[EN_VBLANK]) begin
            res_next.stat_irq = 1'b1;
          end
          if (line_next == VBLANK_LINE) begin
            res_next.vblank_irq = 1'b1;
          end
        end
      end else if (dot_next <= OAM_END) begin
        mode_next = MODE_OAM;
      end else if (dot_next <= DRAW_END) begin
        if (mode_next != MODE_DRAW) begin
          res_next.draw_line = 1'b1;
          mode_next          = MODE_DRAW;
        end
      end else if (dot_next <= DOTS_PER_LINE) begin
        if (mode_next != MODE_HBLANK) begin
          mode_next = MODE_HBLANK;
          if (in_item.stat_enables[EN_HBLANK]) begin
            res_next.stat_irq = 1'b1;
          end
        end
      end
    end else begin
      line_next = 8'd0;
    end
    res_next.line        = line_next;
    res_next.mode        = mode_next;
    res_next.coincidence = coincidence_next;
  end

  // Timer state, updated once per processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count       <= '0;
      line_reg        <= '0;
      mode_reg        <= MODE_HBLANK;
      coincidence_reg <= 1'b0;
    end else if (advance) begin
      dot_count       <= dot_next;
      line_reg        <= line_next;
      mode_reg        <= mode_next;
      coincidence_reg <= coincidence_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(out_item_t)){1'b0}}, res};

endmodule

>>> design/lcdsm_checker.sv
// ----------------------------------------------------------------------------
// lcdsm_checker
// Port-level checks for the LCD scanline and mode timer.
// ----------------------------------------------------------------------------
module lcdsm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [lcdsm_pkg::OUT_DATA_W-1:0] m_tdata
);
  import lcdsm_pkg::*;

  // Drop any pending result on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Line never passes the last line of the frame
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] <= LAST_LINE)
    else $error("line out of range");

  // Frame strobe comes with line zero; vblank interrupt only at its first line
  a_frame_vblank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[14] || m_tdata[7:0] == 8'd0) &&
                 (!m_tdata[12] || (m_tdata[7:0] == VBLANK_LINE &&
                                   m_tdata[9:8] == MODE_VBLANK)))
    else $error("frame or vblank strobe at wrong line");

  // Draw strobe only in draw mode on a visible line
  a_draw_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> m_tdata[9:8] == MODE_DRAW &&
                                m_tdata[7:0] <= LAST_VISIBLE_LINE)
    else $error("draw strobe outside draw mode");

endmodule

bind lcd_scanline_mode_timer lcdsm_checker u_lcdsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD scanline and mode timer. A short directed
// walk covers the disabled screen, the OAM, draw and hblank thresholds and a
// line advance with a compare hit. Random steps then run long stretches of
// lines with compare hits, mode changes and occasional screen-off transactions.
// Every result is checked field by field against the typed-in result of its
// directed row, else an in-bench timing predictor. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lcdsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_STEPS = 680;

  // One row of the directed walk: stimulus plus an optional typed-in result
  typedef struct packed {
    in_item_t  stim;
    logic      has_want;
    out_item_t want;
  } dir_row_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predicted timer state
  logic [9:0] tm_dots  = '0;
  logic [7:0] tm_line  = '0;
  logic [1:0] tm_mode  = MODE_HBLANK;
  logic       tm_coin  = 1'b0;

  out_item_t   pending_status[$];
  dir_row_t    stim_rows[$];
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  int unsigned error_count  = 0;
  int unsigned sent_steps   = 0;
  int unsigned results_seen = 0;
  int unsigned frames_seen  = 0;
  int unsigned vblank_seen  = 0;
  int unsigned draw_seen    = 0;
  int unsigned stat_seen    = 0;
  int unsigned coin_seen    = 0;
  int unsigned off_seen     = 0;

  lcd_scanline_mode_timer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Free-running clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lcd_scanline_mode_timer test failed");
      $finish;
    end
  end

  // Advance the predicted timer by one step and return the expected status
  function automatic out_item_t step_timer(in_item_t it);
    out_item_t res;
    res = '0;
    if (it.lcd_enable) begin
      tm_dots = tm_dots + 10'(it.cycles);
      // Line advance, compare, frame wrap
      if (tm_dots > DOTS_PER_LINE) begin
        tm_line = tm_line + 8'd1;
        tm_coin = (tm_line == it.compare_line);
        if (tm_coin && it.stat_enables[EN_COMPARE]) res.stat_irq = 1'b1;
        if (tm_line > LAST_LINE) begin
          res.frame_done = 1'b1;
          tm_mode        = MODE_OAM;
          tm_line        = '0;
          if (it.stat_enables[EN_OAM]) res.stat_irq = 1'b1;
        end
        tm_dots = tm_dots - DOTS_PER_LINE;
      end
      // Mode select
      if (tm_line > LAST_VISIBLE_LINE) begin
        if (tm_mode != MODE_VBLANK) begin
          tm_mode = MODE_VBLANK;
          if (it.stat_enables[EN_VBLANK]) res.stat_irq = 1'b1;
          if (tm_line == VBLANK_LINE) res.vblank_irq = 1'b1;
        end
      end else if (tm_dots <= OAM_END) begin
        tm_mode = MODE_OAM;
      end else if (tm_dots <= DRAW_END) begin
        if (tm_mode != MODE_DRAW) begin
          res.draw_line = 1'b1;
          tm_mode       = MODE_DRAW;
        end
      end else if (tm_mode != MODE_HBLANK) begin
        tm_mode = MODE_HBLANK;
        if (it.stat_enables[EN_HBLANK]) res.stat_irq = 1'b1;
      end
    end else begin
      tm_line = '0;
    end
    res.line        = tm_line;
    res.mode        = tm_mode;
    res.coincidence = tm_coin;
    return res;
  endfunction

  function automatic in_item_t stim(int unsigned cyc, int unsigned ena,
                                    int unsigned cmp, int unsigned stat);
    in_item_t it;
    it.cycles       = 6'(cyc);
    it.lcd_enable   = 1'(ena);
    it.compare_line = 8'(cmp);
    it.stat_enables = 4'(stat);
    return it;
  endfunction

  function automatic out_item_t status(logic [7:0] line, logic [1:0] mode, logic coin,
                                       logic stat, logic vb, logic draw, logic frame);
    out_item_t o;
    o.line        = line;
    o.mode        = mode;
    o.coincidence = coin;
    o.stat_irq    = stat;
    o.vblank_irq  = vb;
    o.draw_line   = draw;
    o.frame_done  = frame;
    return o;
  endfunction

  function automatic dir_row_t row(in_item_t s, logic has_want, out_item_t w);
    dir_row_t r;
    r.stim     = s;
    r.has_want = has_want;
    r.want     = w;
    return r;
  endfunction

  // Offer one transaction, hold it until taken, then record its expectation
  task automatic push_step(input in_item_t it, input logic has_want, input out_item_t want);
    out_item_t predicted;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(in_item_t)){1'b0}}, it};
    do @(posedge clk); while (!s_tready);
    predicted = step_timer(it);
    pending_status.push_back(has_want ? want : predicted);
    sent_steps++;
    if (!it.lcd_enable) off_seen++;
    if (predicted.frame_done) frames_seen++;
  endtask

  // Drop valid for a number of cycles
  task automatic pause_sender(input int unsigned n);
    if (n != 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected status has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((sent_steps % 200) < 40) return 0;
    r = $urandom_range(0, 31);
    if (r < 20) return 0;
    if (r < 30) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Random receiver stalls, with stretches of steady ready
  always @(posedge clk) begin : ready_gen
    int unsigned r;
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((cycle_count % 512) < 96) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 31);
      if (r < 22) begin
        m_tready <= 1'b1;
      end else if (r < 30) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(3, 23);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
      results_seen++;
      if (pending_status.size() == 0) begin
        $error("unexpected result transaction %h", m_tdata);
        error_count++;
      end else begin
        want = pending_status.pop_front();
        if (got.line != want.line) begin
          $error("line: expected %0d, got %0d", want.line, got.line);
          error_count++;
        end
        if (got.mode != want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, got.mode);
          error_count++;
        end
        if (got.coincidence != want.coincidence) begin
          $error("coincidence: expected %0d, got %0d", want.coincidence, got.coincidence);
          error_count++;
        end
        if (got.stat_irq != want.stat_irq) begin
          $error("stat_irq: expected %0d, got %0d", want.stat_irq, got.stat_irq);
          error_count++;
        end
        if (got.vblank_irq != want.vblank_irq) begin
          $error("vblank_irq: expected %0d, got %0d", want.vblank_irq, got.vblank_irq);
          error_count++;
        end
        if (got.draw_line != want.draw_line) begin
          $error("draw_line: expected %0d, got %0d", want.draw_line, got.draw_line);
          error_count++;
        end
        if (got.frame_done != want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
          error_count++;
        end
        if (want.vblank_irq) vblank_seen++;
        if (want.draw_line) draw_seen++;
        if (want.stat_irq) stat_seen++;
        if (want.coincidence) coin_seen++;
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    in_item_t    it;
    out_item_t   none;
    int unsigned r;
    int unsigned rand_steps;
    none = '0;

    // Directed walk through one line, starting from reset state
    stim_rows.push_back(row(stim(0, 0, 0, 0), 1'b1,
                            status(0, MODE_HBLANK, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(stim(63, 0, 255, 15), 1'b1,
                            status(0, MODE_HBLANK, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(stim(0, 1, 0, 0), 1'b1,
                            status(0, MODE_OAM, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(stim(63, 1, 255, 15), 1'b1,
                            status(0, MODE_OAM, 0, 0, 0, 0, 0)));
    // OAM upper edge, then entry to draw
    stim_rows.push_back(row(stim(17, 1, 0, 0), 1'b1,
                            status(0, MODE_OAM, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(stim(1, 1, 0, 15), 1'b1,
                            status(0, MODE_DRAW, 0, 0, 0, 1, 0)));
    stim_rows.push_back(row(stim(63, 1, 0, 15), 1'b0, none));
    stim_rows.push_back(row(stim(63, 1, 0, 15), 1'b0, none));
    stim_rows.push_back(row(stim(45, 1, 0, 15), 1'b0, none));
    // Entry to hblank with its interrupt enabled
    stim_rows.push_back(row(stim(1, 1, 0, 15), 1'b1,
                            status(0, MODE_HBLANK, 0, 1, 0, 0, 0)));
    // Screen off mid-line: dots and mode held
    stim_rows.push_back(row(stim(0, 0, 0, 15), 1'b1,
                            status(0, MODE_HBLANK, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(stim(63, 1, 0, 0), 1'b0, none));
    stim_rows.push_back(row(stim(63, 1, 0, 0), 1'b0, none));
    stim_rows.push_back(row(stim(63, 1, 0, 0), 1'b0, none));
    stim_rows.push_back(row(stim(14, 1, 0, 0), 1'b0, none));
    // Line advance with a compare hit
    stim_rows.push_back(row(stim(1, 1, 1, 15), 1'b1,
                            status(1, MODE_OAM, 1, 1, 0, 0, 0)));
    stim_rows.push_back(row(stim(0, 1, 1, 0), 1'b0, none));
    stim_rows.push_back(row(stim(63, 0, 200, 15), 1'b0, none));
    stim_rows.push_back(row(stim(63, 1, 42, 8), 1'b0, none));
    stim_rows.push_back(row(stim(6'b101010, 1, 8'hAA, 4'b1010), 1'b0, none));
    stim_rows.push_back(row(stim(6'b010101, 1, 8'h55, 4'b0101), 1'b0, none));

    // Hold reset, then release it before the directed walk
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      push_step(stim_rows[i].stim, stim_rows[i].has_want, stim_rows[i].want);
      pause_sender(pick_gap());
    end
    drain_results();

    // Random lines: mostly enabled, long batches, compare near the line
    rand_steps = 0;
    while (rand_steps < RANDOM_STEPS) begin
      if (rand_steps != 0 && (rand_steps % 300) == 0) drain_results();
      r = $urandom_range(0, 15);
      if (r < 11)      it.cycles = 6'($urandom_range(40, 63));
      else if (r < 14) it.cycles = 6'($urandom_range(0, 63));
      else             it.cycles = '0;
      it.lcd_enable = 1'b1;
      if (tm_line < 8 && $urandom_range(0, 63) == 0) it.lcd_enable = 1'b0;
      if (tm_line >= 150 && $urandom_range(0, 199) == 0) it.lcd_enable = 1'b0;
      r = $urandom_range(0, 7);
      case (r)
        0, 1, 2: it.compare_line = tm_line + 8'd1;
        3:       it.compare_line = tm_line;
        4:       it.compare_line = LAST_LINE + 8'd1;
        5:       it.compare_line = VBLANK_LINE;
        default: it.compare_line = 8'($urandom_range(0, 255));
      endcase
      it.stat_enables = 4'($urandom_range(0, 15));
      push_step(it, 1'b0, none);
      rand_steps++;
      pause_sender(pick_gap());
    end

    // Wait for the tail, then keep watching for stray results
    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d steps (%0d screen off), %0d results, %0d frames",
             sent_steps, off_seen, results_seen, frames_seen);
    $display("seen %0d vblank irqs, %0d stat irqs, %0d draw strobes, %0d compare hits",
             vblank_seen, stat_seen, draw_seen, coin_seen);
    if (error_count == 0) begin
      $display("lcd_scanline_mode_timer test passed");
    end else begin
      $display("lcd_scanline_mode_timer test failed");
    end
    $finish;
  end

endmodule
